// ===== rtl/sts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  // Result queue geometry: one source byte causes at most three tokens.
  localparam int MaxBurst  = 3;
  localparam int ResQDepth = 4;
  localparam int ResQIdxW  = $clog2(ResQDepth);
  localparam int ResQCntW  = $clog2(ResQDepth + 1);

  // Character codes with a special meaning to the scanner.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChGt    = 8'h3E;

  typedef enum logic [5:0] {
    K_EOF       = 6'd0,
    K_ERR       = 6'd1,
    K_IDENT     = 6'd2,
    K_INT       = 6'd3,
    K_FLOAT     = 6'd4,
    K_STRING    = 6'd5,
    K_ELSE      = 6'd6,
    K_FALSE     = 6'd7,
    K_FOR       = 6'd8,
    K_FUNC      = 6'd9,
    K_IF        = 6'd10,
    K_LET       = 6'd11,
    K_PRINT     = 6'd12,
    K_RETURN    = 6'd13,
    K_TRUE      = 6'd14,
    K_WHILE     = 6'd15,
    K_LPAREN    = 6'd16,
    K_RPAREN    = 6'd17,
    K_LBRACE    = 6'd18,
    K_RBRACE    = 6'd19,
    K_SEMI      = 6'd20,
    K_COMMA     = 6'd21,
    K_DOT       = 6'd22,
    K_MINUS     = 6'd23,
    K_PERCENT   = 6'd24,
    K_PLUS      = 6'd25,
    K_SLASH     = 6'd26,
    K_STAR      = 6'd27,
    K_AMP       = 6'd28,
    K_BAR       = 6'd29,
    K_BANG      = 6'd30,
    K_EQUAL     = 6'd31,
    K_LESS      = 6'd32,
    K_GREATER   = 6'd33,
    K_BANGEQ    = 6'd34,
    K_EQEQ      = 6'd35,
    K_LESSEQ    = 6'd36,
    K_GREATEREQ = 6'd37
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_OPEN_STR = 2'd2
  } err_kind_e;

  // First six bytes of a word, byte 0 is the first character.
  typedef logic [5:0][7:0] pfx_t;

  typedef struct packed {
    tok_kind_e   kind;
    err_kind_e   err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [MaxBurst-1:0] res;
    logic [1:0]          cnt;
  } burst_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic tok_kind_e punct_kind(input logic [7:0] c);
    tok_kind_e k;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      ".": k = K_DOT;
      "-": k = K_MINUS;
      "%": k = K_PERCENT;
      "+": k = K_PLUS;
      "/": k = K_SLASH;
      "*": k = K_STAR;
      "&": k = K_AMP;
      "|": k = K_BAR;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  // len is the word length clipped to 7 (7 = longer than any keyword).
  function automatic tok_kind_e word_kind(input pfx_t p, input logic [2:0] len);
    tok_kind_e k;
    k = K_IDENT;
    case (len)
      3'd2: begin
        if ({p[0], p[1]} == "if") k = K_IF;
      end
      3'd3: begin
        if ({p[0], p[1], p[2]} == "for") k = K_FOR;
        else if ({p[0], p[1], p[2]} == "let") k = K_LET;
      end
      3'd4: begin
        if ({p[0], p[1], p[2], p[3]} == "else") k = K_ELSE;
        else if ({p[0], p[1], p[2], p[3]} == "func") k = K_FUNC;
        else if ({p[0], p[1], p[2], p[3]} == "true") k = K_TRUE;
      end
      3'd5: begin
        if ({p[0], p[1], p[2], p[3], p[4]} == "false") k = K_FALSE;
        else if ({p[0], p[1], p[2], p[3], p[4]} == "print") k = K_PRINT;
        else if ({p[0], p[1], p[2], p[3], p[4]} == "while") k = K_WHILE;
      end
      3'd6: begin
        if ({p[0], p[1], p[2], p[3], p[4], p[5]} == "return") k = K_RETURN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sts_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sts_core #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    char_i,
  input  wire logic          fire_i,
  output sts_pkg::burst_t    burst_o
);
  import sts_pkg::*;

  localparam int OffW  = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam int LineW = (LINE_BITS > 16) ? LINE_BITS : 16;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_WORD, M_INT, M_INTDOT, M_FRAC, M_STR,
    M_BANG, M_EQ, M_LT, M_GT
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  pfx_t                   pfx_q, pfx_d;

  function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] v);
    logic [OffW-1:0] w;
    w = OffW'(v);
    return w[15:0];
  endfunction

  function automatic logic [15:0] line16(input logic [LINE_BITS-1:0] v);
    logic [LineW-1:0] w;
    w = LineW'(v);
    return w[15:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] e,
                                                  input logic [OFFSET_BITS-1:0] s);
    return (e >= s) ? e - s : '0;
  endfunction

  logic [OFFSET_BITS-1:0] wspan, dot_pos;
  logic [2:0]             wlen;
  logic [1:0]             n;
  logic                   used, ended;
  logic [7:0]             c;
  res_t [MaxBurst-1:0]    res;
  tok_kind_e              single, twin;

  assign c       = char_i;
  assign wspan   = span(pos_q, start_q);
  assign wlen    = (wspan > OFFSET_BITS'(6)) ? 3'd7 : wspan[2:0];
  assign dot_pos = (pos_q > start_q) ? pos_q - OFFSET_BITS'(1) : start_q;

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    pos_d   = pos_q;
    line_d  = line_q;
    pfx_d   = pfx_q;
    used    = 1'b0;
    ended   = 1'b0;
    n       = 2'd0;
    single  = K_BANG;
    twin    = K_BANGEQ;
    for (int i = 0; i < MaxBurst; i++) begin
      res[i] = '{kind: K_EOF, err: ERR_NONE, start: '0, len: '0,
                 line: line16(line_q), last: 1'b0};
    end

    // Finish or extend the pending token.
    case (mode_q)
      M_COMMENT: begin
        if (c == ChLf || c == ChNul) mode_d = M_IDLE;
        else used = 1'b1;
      end
      M_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (wspan < OFFSET_BITS'(6)) pfx_d[wspan[2:0]] = c;
          used = 1'b1;
        end else begin
          res[n].kind  = word_kind(pfx_q, wlen);
          res[n].start = off16(start_q);
          res[n].len   = off16(wspan);
          n            = n + 2'd1;
          mode_d       = M_IDLE;
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          used = 1'b1;
        end else if (c == ChDot) begin
          mode_d = M_INTDOT;
          used   = 1'b1;
        end else begin
          res[n].kind  = K_INT;
          res[n].start = off16(start_q);
          res[n].len   = off16(wspan);
          n            = n + 2'd1;
          mode_d       = M_IDLE;
        end
      end
      M_INTDOT: begin
        if (is_digit(c)) begin
          mode_d = M_FRAC;
          used   = 1'b1;
        end else begin
          // Digits and a dot with no fraction: an int, then the dot itself.
          res[n].kind  = K_INT;
          res[n].start = off16(start_q);
          res[n].len   = off16(span(dot_pos, start_q));
          n            = n + 2'd1;
          res[n].kind  = K_DOT;
          res[n].start = off16(dot_pos);
          res[n].len   = 16'd1;
          n            = n + 2'd1;
          mode_d       = M_IDLE;
        end
      end
      M_FRAC: begin
        if (is_digit(c)) begin
          used = 1'b1;
        end else begin
          res[n].kind  = K_FLOAT;
          res[n].start = off16(start_q);
          res[n].len   = off16(wspan);
          n            = n + 2'd1;
          mode_d       = M_IDLE;
        end
      end
      M_STR: begin
        if (c == ChQuote) begin
          res[n].kind  = K_STRING;
          res[n].start = off16(start_q);
          res[n].len   = off16(wspan) + 16'd1;
          n            = n + 2'd1;
          mode_d       = M_IDLE;
          used         = 1'b1;
        end else if (c == ChNul) begin
          res[n].kind  = K_ERR;
          res[n].err   = ERR_OPEN_STR;
          res[n].start = off16(start_q);
          n            = n + 2'd1;
          mode_d       = M_IDLE;
        end else begin
          if (c == ChLf && line_q != '1) line_d = line_q + LINE_BITS'(1);
          used = 1'b1;
        end
      end
      M_BANG, M_EQ, M_LT, M_GT: begin
        case (mode_q)
          M_EQ: begin
            single = K_EQUAL;
            twin   = K_EQEQ;
          end
          M_LT: begin
            single = K_LESS;
            twin   = K_LESSEQ;
          end
          M_GT: begin
            single = K_GREATER;
            twin   = K_GREATEREQ;
          end
          default: begin
            single = K_BANG;
            twin   = K_BANGEQ;
          end
        endcase
        mode_d       = M_IDLE;
        res[n].start = off16(start_q);
        if (c == ChEq) begin
          res[n].kind = twin;
          res[n].len  = 16'd2;
          used        = 1'b1;
        end else begin
          res[n].kind = single;
          res[n].len  = 16'd1;
        end
        n = n + 2'd1;
      end
      default: mode_d = M_IDLE;
    endcase

    // Byte not taken by a pending token: start something new.
    if (!used) begin
      if (c == ChNul) begin
        res[n].kind  = K_EOF;
        res[n].start = off16(pos_q);
        n            = n + 2'd1;
        ended        = 1'b1;
      end else if (c == ChSpace || c == ChTab || c == ChCr) begin
        mode_d = mode_d;
      end else if (c == ChLf) begin
        if (line_q != '1) line_d = line_q + LINE_BITS'(1);
      end else if (c == ChHash) begin
        mode_d = M_COMMENT;
      end else if (is_alpha(c)) begin
        mode_d   = M_WORD;
        start_d  = pos_q;
        pfx_d    = '0;
        pfx_d[0] = c;
      end else if (is_digit(c)) begin
        mode_d  = M_INT;
        start_d = pos_q;
      end else if (c == ChQuote) begin
        mode_d  = M_STR;
        start_d = pos_q;
      end else if (c == ChBang) begin
        mode_d  = M_BANG;
        start_d = pos_q;
      end else if (c == ChEq) begin
        mode_d  = M_EQ;
        start_d = pos_q;
      end else if (c == ChLt) begin
        mode_d  = M_LT;
        start_d = pos_q;
      end else if (c == ChGt) begin
        mode_d  = M_GT;
        start_d = pos_q;
      end else if (punct_kind(c) != K_EOF) begin
        res[n].kind  = punct_kind(c);
        res[n].start = off16(pos_q);
        res[n].len   = 16'd1;
        n            = n + 2'd1;
      end else begin
        res[n].kind  = K_ERR;
        res[n].err   = ERR_BAD_CHAR;
        res[n].start = off16(pos_q);
        n            = n + 2'd1;
      end
    end

    // End of source returns everything to its reset value.
    if (ended) begin
      mode_d  = M_IDLE;
      start_d = '0;
      pos_d   = '0;
      line_d  = LINE_BITS'(1);
      pfx_d   = '0;
    end else if (pos_q != '1) begin
      pos_d = pos_q + OFFSET_BITS'(1);
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  assign burst_o.res = res;
  assign burst_o.cnt = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= LINE_BITS'(1);
      pfx_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      pfx_q   <= pfx_d;
    end
  end

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count dropped to zero");

endmodule

`default_nettype wire

// ===== rtl/sts_res_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sts_res_fifo (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_en_i,
  input  wire sts_pkg::burst_t           push_i,
  input  wire logic                      pop_i,
  output sts_pkg::res_t                  head_o,
  output logic                           valid_o,
  output logic [sts_pkg::ResQCntW-1:0]   free_o
);
  import sts_pkg::*;

  res_t                mem [ResQDepth];
  logic [ResQIdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResQCntW-1:0] count_q, count_d;
  logic [1:0]          push_n;

  assign push_n  = push_en_i ? push_i.cnt : 2'd0;
  assign count_d = count_q + ResQCntW'(push_n) - ResQCntW'(pop_i);
  assign valid_o = count_q != '0;
  assign free_o  = ResQCntW'(ResQDepth) - count_q;
  assign head_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxBurst; i++) begin
      if (2'(i) < push_n) mem[wr_ptr_q + ResQIdxW'(i)] <= push_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResQIdxW'(push_n);
      rd_ptr_q <= rd_ptr_q + ResQIdxW'(pop_i);
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en_i |-> free_o >= ResQCntW'(push_i.cnt))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("result queue underflow");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && push_n == 2'd0) |=> count_q == $past(count_q) - ResQCntW'(1))
    else $error("queue fill count lost track of a pop");

endmodule

`default_nettype wire

// ===== rtl/script_token_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexical scanner for a small script language.
// Slave side: one source byte per request on s_axis_tdata_i; byte 0 ends the
// source, flushes any pending token and emits an EOF token.
// Master side: one token per request. tuser carries the token kind and error
// code, tdata carries start offset, length and line; tlast marks the final
// token caused by one source byte (a byte causes zero to three tokens).
// Path: a taken byte is held in the input register, scanned, and its tokens
// go to the result queue, presented once no earlier tokens still wait there.
// Throughput: one byte per cycle while the four-entry result queue has room
// for all tokens of the held byte. The queue drains one token per cycle while
// the receiver is ready, so bytes that yield two or three tokens in close
// succession hold the input register (tready low) until enough have left.
// Reset: scanner state returns to offset 0, line 1, between tokens; the queue
// empties. After an end-of-source byte the same reset state is taken.
// Receiver stall: tokens wait in the queue; once it lacks room for the held
// byte's tokens, tready drops.
module script_token_scanner #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [15:0] start_offset,
                                             // [31:16] token_length,
                                             // [47:32] line_number
  output logic [7:0]       m_axis_tuser_o,   // [5:0] token_kind, [7:6] error_kind
  output logic             m_axis_tlast_o    // last_of_run
);
  import sts_pkg::*;

  // Input register: one byte waiting to be scanned.
  logic                in_valid_q;
  logic [7:0]          in_char_q;
  logic                fire;
  burst_t              burst;
  res_t                head;
  logic                q_valid;
  logic [ResQCntW-1:0] q_free;

  // A byte is scanned once the queue can hold every token it produces.
  assign fire            = in_valid_q && (q_free >= ResQCntW'(burst.cnt));
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_char_q  <= '0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
      in_char_q  <= s_axis_tdata_i;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  sts_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (in_char_q),
    .fire_i (fire),
    .burst_o(burst)
  );

  sts_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(fire),
    .push_i   (burst),
    .pop_i    (m_axis_tvalid_o && m_axis_tready_i),
    .head_o   (head),
    .valid_o  (q_valid),
    .free_o   (q_free)
  );

  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tdata_o  = {head.line, head.len, head.start};
  assign m_axis_tuser_o  = {head.err, head.kind};
  assign m_axis_tlast_o  = head.last;

endmodule

`default_nettype wire
